/* hdl/amadt_pkg.sv */
// shared constants, record types and entry buffer type for the madt entry parser
package amadt_pkg;

	localparam int DEF_MAX_PROCESSORS = 16;
	localparam int DEF_MAX_OVERRIDES  = 24;

	localparam int KIND_W    = 3;
	localparam int TDATA_W   = 112;
	localparam int ROOM_W    = 34;
	localparam int EBUF_DEPTH = 12;
	localparam int EBUF_IDX_W = $clog2(EBUF_DEPTH);

	localparam logic [KIND_W-1:0] KIND_LAPIC    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CPU      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IOAPIC   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OVERRIDE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_HALT     = 3'd4;

	localparam logic [7:0] ET_LOCAL_APIC = 8'd0;
	localparam logic [7:0] ET_IO_APIC    = 8'd1;
	localparam logic [7:0] ET_OVERRIDE   = 8'd2;

	localparam logic [7:0] ENTRY_MIN_LEN  = 8'd2;
	localparam logic [7:0] PROC_MIN_LEN   = 8'd8;
	localparam logic [7:0] IOAPIC_MIN_LEN = 8'd12;
	localparam logic [7:0] ISO_MIN_LEN    = 8'd10;
	localparam logic [7:0] ENABLE_MASK    = 8'h03;

	localparam logic [31:0] LEN_OFFSET   = 32'd4;
	localparam logic [31:0] LAPIC_OFFSET = 32'd36;
	localparam logic [31:0] ENTRY_START  = 32'd44;

	// remaining table bytes from the entry start, as it stands after reset
	localparam logic signed [ROOM_W-1:0] ROOM_RESET = -ROOM_W'(44);
	localparam logic signed [ROOM_W-1:0] ROOM_TWO   = ROOM_W'(2);

	typedef logic [EBUF_DEPTH-1:0][7:0] ebuf_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [31:0]       address_word;
		logic [7:0]        apic_id;
		logic [7:0]        processor_number;
		logic [7:0]        source_irq;
		logic [31:0]       gsi_value;
		logic [15:0]       override_flags;
		logic [7:0]        slot_index;
	} rec_t;

	typedef struct packed {
		logic emit;
		logic cpu_take;
		logic ovr_take;
		rec_t rec;
	} dec_t;

endpackage

/* hdl/acpi_madt_entry_parser.sv */
// Takes an ACPI MADT table one byte per item, little-endian, from offset 0 (tuser
// high on the item at offset 0 restarts all counts). It emits the local APIC base
// once byte 39 arrives, then walks the type/length entries from offset 44 and
// emits one record on the last byte of each enabled processor, I/O APIC or
// interrupt source override entry of its minimum length or more, processors and
// overrides up to their limits; an entry length below 2 or an entry running past
// the table length stops the walk with a halt record. One byte is taken every
// cycle unless the output stalls: each byte passes an input register, entry
// tracking and decode against a running count of the bytes left in the table,
// and a result register, so a record shows on m_tvalid once its last byte has
// passed both registers. The result register is the only buffer on the output,
// so while a record waits on m_tready, the input item waits and holds s_tready low.
module acpi_madt_entry_parser import amadt_pkg::*; #(
	parameter int MAX_PROCESSORS = DEF_MAX_PROCESSORS,
	parameter int MAX_OVERRIDES  = DEF_MAX_OVERRIDES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // data_byte
	input  logic [0:0]         s_tuser,  // first_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	// address_word, apic_id, processor_number, source_irq, gsi_value,
	// override_flags, slot_index
	output logic [TDATA_W-1:0] m_tdata,
	output logic [KIND_W-1:0]  m_tuser   // record_kind
);

	localparam int CPU_W = $clog2(MAX_PROCESSORS + 1);
	localparam int OVR_W = $clog2(MAX_OVERRIDES + 1);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	// parser state
	logic [31:0]              pos_q;
	logic signed [ROOM_W-1:0] room_q;
	logic [7:0]               rel_q;
	logic [7:0]               size_q;
	logic [31:0]              lapic_q;
	logic                     halt_q;
	logic [CPU_W-1:0]         cpu_q;
	logic [OVR_W-1:0]         ovr_q;
	ebuf_t                    buf_q;

	// result register
	logic              out_valid_q;
	logic [TDATA_W-1:0] out_data_q;
	logic [KIND_W-1:0] out_kind_q;

	logic                     adv;
	logic [31:0]              e_pos;
	logic signed [ROOM_W-1:0] e_room;
	logic [7:0]               e_rel;
	logic [7:0]               e_size;
	logic [31:0]              e_lapic;
	logic                     e_halt;
	logic [CPU_W-1:0]         e_cpu;
	logic [OVR_W-1:0]         e_ovr;

	logic                     sat;
	logic [1:0]               lane;
	logic                     in_len;
	logic                     in_lapic;
	logic                     active;
	logic                     rel1;
	logic [7:0]               size_eff;
	logic                     room_short;
	logic                     bad_len;
	logic                     halt_quiet;
	logic                     halt_rec;
	logic                     fin;
	logic signed [ROOM_W-1:0] byte_room;
	ebuf_t                    cur;
	dec_t                     dec;
	rec_t                     rec;
	logic                     emit;

	logic [31:0]              nx_pos;
	logic signed [ROOM_W-1:0] nx_room;
	logic [7:0]               nx_rel;
	logic [7:0]               nx_size;
	logic [31:0]              nx_lapic;
	logic                     nx_halt;
	logic [CPU_W-1:0]         nx_cpu;
	logic [OVR_W-1:0]         nx_ovr;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser[0];
		end
	end

	// a first byte starts from the reset state
	always_comb begin
		e_pos   = first_s1 ? '0 : pos_q;
		e_room  = first_s1 ? ROOM_RESET : room_q;
		e_rel   = first_s1 ? '0 : rel_q;
		e_size  = first_s1 ? '0 : size_q;
		e_lapic = first_s1 ? '0 : lapic_q;
		e_halt  = first_s1 ? 1'b0 : halt_q;
		e_cpu   = first_s1 ? '0 : cpu_q;
		e_ovr   = first_s1 ? '0 : ovr_q;
	end

	always_comb begin
		sat        = &e_pos;
		lane       = e_pos[1:0];
		in_len     = e_pos >= LEN_OFFSET && e_pos <= LEN_OFFSET + 32'd3;
		in_lapic   = e_pos >= LAPIC_OFFSET && e_pos <= LAPIC_OFFSET + 32'd3;
		active     = !e_halt && e_pos >= ENTRY_START;
		rel1       = e_rel == 8'd1;
		size_eff   = rel1 ? byte_s1 : e_size;
		byte_room  = $signed(ROOM_W'(byte_s1));
		room_short = e_room < ROOM_TWO;
		bad_len    = byte_s1 < ENTRY_MIN_LEN || byte_room > e_room;
		halt_quiet = active && rel1 && room_short;
		halt_rec   = active && rel1 && !room_short && bad_len;
		fin        = active && e_rel != 8'd0 && !halt_quiet && !halt_rec &&
		             ({1'b0, e_rel} + 9'd1 == {1'b0, size_eff});
		for (int i = 0; i < EBUF_DEPTH; i++) begin
			cur[i] = (active && e_rel == 8'(i)) ? byte_s1 : buf_q[i];
		end
	end

	amadt_entry_dec #(
		.MAX_PROCESSORS(MAX_PROCESSORS),
		.MAX_OVERRIDES (MAX_OVERRIDES),
		.CPU_W         (CPU_W),
		.OVR_W         (OVR_W)
	) u_dec (
		.entry     (cur),
		.entry_size(size_eff),
		.cpu_taken (e_cpu),
		.ovr_count (e_ovr),
		.dec       (dec)
	);

	always_comb begin
		nx_pos = sat ? e_pos : e_pos + 32'd1;

		// room tracks table length minus the current entry start
		nx_room = e_room;
		if (in_len) begin
			nx_room = e_room + (ROOM_W'(byte_s1) << {lane, 3'b000});
		end else if (fin) begin
			nx_room = e_room - ROOM_W'(size_eff);
		end

		nx_lapic = in_lapic ? (e_lapic | (32'(byte_s1) << {lane, 3'b000})) : e_lapic;
		nx_halt  = e_halt || halt_quiet || halt_rec;
		nx_size  = (active && rel1 && !halt_quiet && !halt_rec) ? byte_s1 : e_size;

		nx_rel = e_rel;
		if (active) begin
			if (fin) begin
				nx_rel = '0;
			end else if (!sat) begin
				nx_rel = e_rel + 8'd1;
			end
		end

		nx_cpu = (fin && dec.cpu_take) ? e_cpu + CPU_W'(1) : e_cpu;
		nx_ovr = (fin && dec.ovr_take) ? e_ovr + OVR_W'(1) : e_ovr;

		rec  = '0;
		emit = 1'b0;
		if (in_lapic && lane == 2'd3) begin
			emit             = 1'b1;
			rec.kind         = KIND_LAPIC;
			rec.address_word = nx_lapic;
		end else if (halt_rec) begin
			emit     = 1'b1;
			rec.kind = KIND_HALT;
		end else if (fin && dec.emit) begin
			emit = 1'b1;
			rec  = dec.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			room_q  <= ROOM_RESET;
			rel_q   <= '0;
			size_q  <= '0;
			lapic_q <= '0;
			halt_q  <= 1'b0;
			cpu_q   <= '0;
			ovr_q   <= '0;
		end else if (adv) begin
			pos_q   <= nx_pos;
			room_q  <= nx_room;
			rel_q   <= nx_rel;
			size_q  <= nx_size;
			lapic_q <= nx_lapic;
			halt_q  <= nx_halt;
			cpu_q   <= nx_cpu;
			ovr_q   <= nx_ovr;
		end
	end

	// entry byte buffer
	always_ff @(posedge clk) begin
		if (adv && active && e_rel < 8'(EBUF_DEPTH)) begin
			buf_q[e_rel[EBUF_IDX_W-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_kind_q <= rec.kind;
			out_data_q <= {rec.slot_index, rec.override_flags, rec.gsi_value,
			               rec.source_irq, rec.processor_number, rec.apic_id,
			               rec.address_word};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

	a_cpu_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cpu_q <= CPU_W'(MAX_PROCESSORS))
		else $error("processor count past its limit");

	a_ovr_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ovr_q <= OVR_W'(MAX_OVERRIDES))
		else $error("override count past its limit");

	a_halt_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_HALT) |-> m_tdata == '0)
		else $error("halt record carries payload");

	a_cpu_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fin && dec.cpu_take) |=> cpu_q == $past(e_cpu) + CPU_W'(1))
		else $error("processor record without count step");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && halt_rec) |=> halt_q)
		else $error("halt record left the walk running");

endmodule

/* hdl/amadt_entry_dec.sv */
// decodes a completed madt entry into a processor, io apic or override record
module amadt_entry_dec import amadt_pkg::*; #(
	parameter int MAX_PROCESSORS = DEF_MAX_PROCESSORS,
	parameter int MAX_OVERRIDES  = DEF_MAX_OVERRIDES,
	parameter int CPU_W          = $clog2(MAX_PROCESSORS + 1),
	parameter int OVR_W          = $clog2(MAX_OVERRIDES + 1)
) (
	input  ebuf_t            entry,
	input  logic [7:0]       entry_size,
	input  logic [CPU_W-1:0] cpu_taken,
	input  logic [OVR_W-1:0] ovr_count,
	output dec_t             dec
);

	logic cpu_room;
	logic ovr_room;

	assign cpu_room = cpu_taken < CPU_W'(MAX_PROCESSORS);
	assign ovr_room = ovr_count < OVR_W'(MAX_OVERRIDES);

	always_comb begin
		dec = '0;
		unique case (entry[0])
			ET_LOCAL_APIC: begin
				if (entry_size >= PROC_MIN_LEN && cpu_room &&
				    (entry[4] & ENABLE_MASK) != 8'd0) begin
					dec.emit                 = 1'b1;
					dec.cpu_take             = 1'b1;
					dec.rec.kind             = KIND_CPU;
					dec.rec.apic_id          = entry[3];
					dec.rec.processor_number = entry[2];
					dec.rec.slot_index       = 8'(cpu_taken);
				end
			end
			ET_IO_APIC: begin
				if (entry_size >= IOAPIC_MIN_LEN) begin
					dec.emit             = 1'b1;
					dec.rec.kind         = KIND_IOAPIC;
					dec.rec.address_word = {entry[7], entry[6], entry[5], entry[4]};
					dec.rec.gsi_value    = {entry[11], entry[10], entry[9], entry[8]};
				end
			end
			ET_OVERRIDE: begin
				if (entry_size >= ISO_MIN_LEN && ovr_room) begin
					dec.emit               = 1'b1;
					dec.ovr_take           = 1'b1;
					dec.rec.kind           = KIND_OVERRIDE;
					dec.rec.source_irq     = entry[3];
					dec.rec.gsi_value      = {entry[7], entry[6], entry[5], entry[4]};
					dec.rec.override_flags = {entry[9], entry[8]};
					dec.rec.slot_index     = 8'(ovr_count);
				end
			end
			default: begin
				dec = '0;
			end
		endcase
	end

endmodule

/* tb/sv/tb_acpi_madt_entry_parser.sv */
// testbench for acpi_madt_entry_parser: streams madt tables and checks every record
`timescale 1ns / 100ps

module tb_acpi_madt_entry_parser;
	import amadt_pkg::*;

	localparam int CPU_LIMIT    = DEF_MAX_PROCESSORS;
	localparam int MAX_OVRS     = DEF_MAX_OVERRIDES;
	localparam int ITEM_TARGET  = 1650;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;

	class madt_scoreboard;
		logic [31:0] byte_pos;
		logic [31:0] tbl_len;
		logic [31:0] entry_start;
		logic [31:0] lapic_acc;
		logic [7:0]  ent_len;
		logic [7:0]  ent_buf [EBUF_DEPTH];
		int unsigned cpus_taken;
		int unsigned ovr_count;
		bit          halted;
		rec_t        record_q[$];
		int unsigned errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			byte_pos    = '0;
			tbl_len     = '0;
			entry_start = ENTRY_START;
			lapic_acc   = '0;
			ent_len     = '0;
			cpus_taken  = 0;
			ovr_count   = 0;
			halted      = 1'b0;
			foreach (ent_buf[i])
				ent_buf[i] = '0;
		endfunction

		function logic [31:0] word_at(int at);
			return {ent_buf[at+3], ent_buf[at+2], ent_buf[at+1], ent_buf[at]};
		endfunction

		// last byte of an entry: decide whether it yields a record
		function void close_entry();
			rec_t rec;
			rec = '0;
			if (ent_buf[0] == ET_LOCAL_APIC && ent_len >= PROC_MIN_LEN &&
			    cpus_taken < CPU_LIMIT) begin
				if ((ent_buf[4] & ENABLE_MASK) != 0) begin
					rec.kind             = KIND_CPU;
					rec.apic_id          = ent_buf[3];
					rec.processor_number = ent_buf[2];
					rec.slot_index       = cpus_taken[7:0];
					cpus_taken++;
					record_q.push_back(rec);
				end
			end else if (ent_buf[0] == ET_IO_APIC && ent_len >= IOAPIC_MIN_LEN) begin
				rec.kind         = KIND_IOAPIC;
				rec.address_word = word_at(4);
				rec.gsi_value    = word_at(8);
				record_q.push_back(rec);
			end else if (ent_buf[0] == ET_OVERRIDE && ent_len >= ISO_MIN_LEN &&
					ovr_count < MAX_OVRS) begin
				rec.kind           = KIND_OVERRIDE;
				rec.source_irq     = ent_buf[3];
				rec.gsi_value      = word_at(4);
				rec.override_flags = {ent_buf[9], ent_buf[8]};
				rec.slot_index     = ovr_count[7:0];
				ovr_count++;
				record_q.push_back(rec);
			end
		endfunction

		function void note_byte(logic [7:0] b, logic first);
			logic [31:0] p;
			logic [31:0] rel;
			rec_t        rec;
			if (first)
				clear();
			p = byte_pos;
			if (byte_pos != 32'hFFFF_FFFF)
				byte_pos++;
			if (p >= LEN_OFFSET && p <= LEN_OFFSET + 3)
				tbl_len |= 32'(b) << (8 * (p - LEN_OFFSET));
			if (p >= LAPIC_OFFSET && p <= LAPIC_OFFSET + 3) begin
				lapic_acc |= 32'(b) << (8 * (p - LAPIC_OFFSET));
				if (p == LAPIC_OFFSET + 3) begin
					rec = '0;
					rec.kind = KIND_LAPIC;
					rec.address_word = lapic_acc;
					record_q.push_back(rec);
				end
				return;
			end
			if (halted || p < entry_start)
				return;
			rel = p - entry_start;
			if (rel < EBUF_DEPTH)
				ent_buf[rel[EBUF_IDX_W-1:0]] = b;
			if (rel == 0)
				return;
			if (rel == 1) begin
				// too little left for another entry header: quiet stop
				if (64'(entry_start) + 64'd2 > 64'(tbl_len)) begin
					halted = 1'b1;
					return;
				end
				if (b < ENTRY_MIN_LEN || 64'(entry_start) + 64'(b) > 64'(tbl_len)) begin
					halted = 1'b1;
					rec = '0;
					rec.kind = KIND_HALT;
					record_q.push_back(rec);
					return;
				end
				ent_len = b;
			end
			if (rel + 1 == 32'(ent_len)) begin
				close_entry();
				entry_start += 32'(ent_len);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_record(logic [KIND_W-1:0] kind, logic [TDATA_W-1:0] data);
			rec_t want;
			if (record_q.size() == 0) begin
				$display("%0t: record with none expected, kind %0d data %h", $time, kind, data);
				errors++;
				return;
			end
			want = record_q.pop_front();
			compare_field("record_kind", 32'(want.kind), 32'(kind));
			compare_field("address_word", want.address_word, data[31:0]);
			compare_field("apic_id", 32'(want.apic_id), 32'(data[39:32]));
			compare_field("processor_number", 32'(want.processor_number), 32'(data[47:40]));
			compare_field("source_irq", 32'(want.source_irq), 32'(data[55:48]));
			compare_field("gsi_value", want.gsi_value, data[87:56]);
			compare_field("override_flags", 32'(want.override_flags), 32'(data[103:88]));
			compare_field("slot_index", 32'(want.slot_index), 32'(data[111:104]));
		endfunction

		function int pending();
			return record_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;  // data_byte
	logic [0:0]         s_tuser;  // first_byte
	logic               m_tvalid;
	logic               m_tready;
	// address_word, apic_id, processor_number, source_irq, gsi_value,
	// override_flags, slot_index
	logic [TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]  m_tuser;  // record_kind

	madt_scoreboard sb;
	logic [7:0]     tbl[$];
	int unsigned    sent_count = 0;
	int unsigned    cycles = 0;
	bit             quiet = 1'b0;
	bit             sender_gaps = 1'b0;

	acpi_madt_entry_parser #(
		.MAX_PROCESSORS(CPU_LIMIT),
		.MAX_OVERRIDES (MAX_OVRS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_acpi_madt_entry_parser: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_record(m_tuser, m_tdata);
			if (s_tvalid && s_tready)
				sb.note_byte(s_tdata, s_tuser[0]);
		end
	end

	// result side back-pressure
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30))
				@(posedge clk);
		end
	end

	function automatic void new_table();
		tbl.delete();
		repeat (ENTRY_START) tbl.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void set_length(logic [31:0] len);
		for (int i = 0; i < 4; i++)
			tbl[LEN_OFFSET + i] = len[8*i +: 8];
	endfunction

	function automatic void pad_bytes(int unsigned count);
		repeat (count) tbl.push_back(8'($urandom_range(0, 255)));
	endfunction

	// appends type, length and random body bytes; returns the entry offset
	function automatic int put_entry(logic [7:0] etype, logic [7:0] elen);
		int at;
		at = tbl.size();
		tbl.push_back(etype);
		tbl.push_back(elen);
		for (int i = 2; i < elen; i++)
			tbl.push_back(8'($urandom_range(0, 255)));
		return at;
	endfunction

	task automatic send_byte(logic [7:0] b, logic first);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		sent_count++;
		if (!quiet && sender_gaps && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic send_table(logic with_first, int unsigned count);
		for (int i = 0; i < count && i < tbl.size(); i++)
			send_byte(tbl[i], with_first && i == 0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		int          at;
		int unsigned n_ent;
		int unsigned pick;
		logic [31:0] len;
		sb = new();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_gaps = 1'b1;

		// header only, no first flag after reset, table too short to walk
		new_table();
		set_length(32'd40);
		for (int i = 0; i < 4; i++)
			tbl[LAPIC_OFFSET + i] = 8'hFF;
		pad_bytes(4);
		send_table(1'b0, tbl.size());

		// every entry kind, disabled and short entries, quiet end with one spare byte
		new_table();
		for (int i = 0; i < 4; i++)
			tbl[LAPIC_OFFSET + i] = 8'h00;
		at = put_entry(ET_LOCAL_APIC, PROC_MIN_LEN);
		tbl[at+4] = 8'h01;
		at = put_entry(ET_LOCAL_APIC, PROC_MIN_LEN);
		tbl[at+2] = 8'hFF;
		tbl[at+3] = 8'hFF;
		tbl[at+4] = 8'h02;
		at = put_entry(ET_LOCAL_APIC, PROC_MIN_LEN);
		tbl[at+4] = 8'hFC;
		at = put_entry(ET_LOCAL_APIC, PROC_MIN_LEN - 8'd1);
		at = put_entry(ET_IO_APIC, IOAPIC_MIN_LEN);
		for (int i = 4; i < 12; i++)
			tbl[at+i] = 8'hFF;
		at = put_entry(ET_IO_APIC, IOAPIC_MIN_LEN - 8'd1);
		at = put_entry(ET_OVERRIDE, ISO_MIN_LEN);
		for (int i = 2; i < 10; i++)
			tbl[at+i] = 8'hFF;
		at = put_entry(ET_OVERRIDE, ISO_MIN_LEN - 8'd1);
		at = put_entry(8'hFF, ENTRY_MIN_LEN);
		set_length(tbl.size() + 1);
		pad_bytes(3);
		send_table(1'b1, tbl.size());

		// zero entry length
		new_table();
		at = put_entry(ET_IO_APIC, IOAPIC_MIN_LEN);
		at = put_entry(ET_OVERRIDE, 8'd0);
		set_length(tbl.size());
		pad_bytes(2);
		send_table(1'b1, tbl.size());

		// entry length of one
		new_table();
		at = put_entry(ET_LOCAL_APIC, 8'd1);
		set_length(tbl.size() + 4);
		pad_bytes(4);
		send_table(1'b1, tbl.size());

		// entry running past the table
		new_table();
		at = put_entry(ET_IO_APIC, IOAPIC_MIN_LEN);
		set_length(tbl.size() - 1);
		send_table(1'b1, tbl.size());

		// smallest table holding an entry, then one just too short
		new_table();
		at = put_entry(8'd3, ENTRY_MIN_LEN);
		set_length(tbl.size());
		send_table(1'b1, tbl.size());
		new_table();
		set_length(32'd45);
		pad_bytes(3);
		send_table(1'b1, tbl.size());

		// new table arriving in the middle of an entry
		new_table();
		at = put_entry(ET_OVERRIDE, ISO_MIN_LEN);
		set_length(tbl.size());
		send_table(1'b1, 50);

		// processor and override limits
		new_table();
		repeat (CPU_LIMIT + 2) begin
			at = put_entry(ET_LOCAL_APIC, PROC_MIN_LEN);
			tbl[at+4] = 8'h01;
		end
		repeat (MAX_OVRS + 2)
			at = put_entry(ET_OVERRIDE, ISO_MIN_LEN);
		at = put_entry(ET_LOCAL_APIC, PROC_MIN_LEN);
		tbl[at+4] = 8'h03;
		set_length(tbl.size());
		send_table(1'b1, tbl.size());
		wait_drained();

		while (sent_count < ITEM_TARGET) begin
			quiet = sent_count > ITEM_TARGET * 17 / 20;
			sender_gaps = $urandom_range(0, 3) != 0;
			new_table();
			n_ent = ($urandom_range(0, 11) == 0) ? $urandom_range(18, 32) : $urandom_range(0, 6);
			for (int k = 0; k < n_ent; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					at = put_entry(ET_LOCAL_APIC,
						($urandom_range(0, 3) == 0) ? 8'($urandom_range(8, 16)) : PROC_MIN_LEN);
					if ($urandom_range(0, 3) != 0)
						tbl[at+4] = {tbl[at+4][7:2], 2'($urandom_range(1, 3))};
					else
						tbl[at+4] = {tbl[at+4][7:2], 2'b00};
				end else if (pick < 50) begin
					at = put_entry(ET_IO_APIC,
						($urandom_range(0, 3) == 0) ? 8'($urandom_range(12, 18)) :
						IOAPIC_MIN_LEN);
				end else if (pick < 80) begin
					at = put_entry(ET_OVERRIDE,
						($urandom_range(0, 3) == 0) ? 8'($urandom_range(10, 16)) : ISO_MIN_LEN);
				end else if (pick < 90) begin
					at = put_entry(8'($urandom_range(3, 255)), 8'($urandom_range(2, 14)));
				end else begin
					case ($urandom_range(0, 2))
						0: at = put_entry(ET_LOCAL_APIC, 8'($urandom_range(2, 7)));
						1: at = put_entry(ET_IO_APIC, 8'($urandom_range(2, 11)));
						default: at = put_entry(ET_OVERRIDE, 8'($urandom_range(2, 9)));
					endcase
				end
			end
			case ($urandom_range(0, 9))
				0: begin
					at = put_entry(8'($urandom_range(0, 255)), 8'($urandom_range(0, 1)));
					len = tbl.size();
				end
				1: len = tbl.size() - $urandom_range(1, 6);
				2: begin
					len = tbl.size() + $urandom_range(2, 12);
					pad_bytes(len - tbl.size());
				end
				3: len = $urandom();
				default: begin
					len = tbl.size() + $urandom_range(0, 1);
					pad_bytes(len - tbl.size());
				end
			endcase
			set_length(len);
			if ($urandom_range(0, 3) == 0)
				pad_bytes($urandom_range(1, 6));
			send_table($urandom_range(0, 19) != 0,
				($urandom_range(0, 9) == 0) ? $urandom_range(1, tbl.size()) : tbl.size());
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_acpi_madt_entry_parser: PASS");
		else
			$display("tb_acpi_madt_entry_parser: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
hdl/amadt_pkg.sv
hdl/amadt_entry_dec.sv
hdl/acpi_madt_entry_parser.sv
tb/sv/tb_acpi_madt_entry_parser.sv
